// ===== design/ffha_pkg.sv =====
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int unsigned HEAP_BYTES_DEF = 4096;
   localparam int unsigned HEADER_BYTES   = 4;
   // Byte addresses and sums of a header position and a 16-bit size.
   localparam int unsigned ADDR_W         = 17;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned REQ_W    = 13;
   localparam int unsigned OFF_W    = 12;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned WORD_W   = 16;

   localparam logic [WORD_W-1:0] MAGIC_WORD = 16'hDEAD;
   localparam logic [WORD_W-1:0] SIZE_MASK  = 16'hFFFE;
   localparam logic [WORD_W-1:0] FREE_BIT   = 16'h0001;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CHECK = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_ZERO_SIZE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_CORRUPT   = 3'd4
   } status_type;

endpackage

// ===== design/ffha_req_if.sv =====
`timescale 1ns / 1ps
interface ffha_req_if import ffha_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [REQ_W-1:0]  request_bytes;
   logic [OFF_W-1:0]  block_offset;

   modport source (output valid, output operation, output request_bytes,
                   output block_offset, input ready);
   modport sink   (input valid, input operation, input request_bytes,
                   input block_offset, output ready);
endinterface

// ===== design/ffha_rsp_if.sv =====
`timescale 1ns / 1ps
interface ffha_rsp_if import ffha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OFF_W-1:0]    data_offset;

   modport source (output valid, output status, output data_offset, input ready);
   modport sink   (input valid, input status, input data_offset, output ready);
endinterface

// ===== design/ffha_ram.sv =====
`timescale 1ns / 1ps
module ffha_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat fields                               Handshake
// req_bus   in   operation, request_bytes, block_offset    valid / ready
// rsp_bus   out  status, data_offset                       valid / ready
//
// One request at a time; the walker visits block headers through one
// single-port RAM, reading each header's size word (check reads the magic
// word first). After reset a clearing pass writes every heap word, with
// req_bus.ready low. The result sits in an output register; a stalled
// rsp_bus does not block the next accept, only that request's final hand-off.
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int unsigned HEAP_BYTES = HEAP_BYTES_DEF
) (
   input logic         clock,
   input logic         reset,
   ffha_req_if.sink    req_bus,
   ffha_rsp_if.source  rsp_bus
);
   localparam int unsigned HEAP_WORDS = HEAP_BYTES / 2;
   localparam int unsigned WA_W       = $clog2(HEAP_WORDS);
   localparam logic [ADDR_W:0] HEAP_END = (ADDR_W + 1)'(HEAP_BYTES);
   localparam logic [ADDR_W:0] HDR_L    = (ADDR_W + 1)'(HEADER_BYTES);
   localparam logic [ADDR_W:0] TWO_L    = (ADDR_W + 1)'(2);
   localparam logic [WORD_W-1:0] INIT_SIZE =
      WORD_W'(((HEAP_BYTES - HEADER_BYTES) / 2) * 2 + 1);
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(HEAP_WORDS - 1);

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b000000000001,
      S_IDLE     = 12'b000000000010,
      S_WALK     = 12'b000000000100,
      S_MAGIC    = 12'b000000001000,
      S_SIZE     = 12'b000000010000,
      S_NXRD     = 12'b000000100000,
      S_NXSZ     = 12'b000001000000,
      S_SPL_MAG  = 12'b000010000000,
      S_SPL_SIZE = 12'b000100000000,
      S_HDR_SIZE = 12'b001000000000,
      S_HDR_MAG  = 12'b010000000000,
      S_RESP     = 12'b100000000000
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [REQ_W:0]        want_ff, want_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [ADDR_W-1:0]     p_ff, p_in;
   logic [ADDR_W-1:0]     prev_p_ff, prev_p_in;
   logic [WORD_W-1:0]     prev_sz_ff, prev_sz_in;
   logic                  prev_free_ff, prev_free_in;
   logic                  have_prev_ff, have_prev_in;
   logic [WORD_W-1:0]     size_ff, size_in;
   logic [ADDR_W-1:0]     nx_ff, nx_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   status_type            res_status_ff, res_status_in;
   logic [OFF_W-1:0]      res_off_ff, res_off_in;
   logic [WA_W-1:0]       clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]      rsp_off_ff, rsp_off_in;

   logic                  req_beat;
   logic [ADDR_W:0]       add_a, add_b, sum, p_ext, p4, nx_ext;
   logic [WORD_W-1:0]     rdata, sz_rd, diff;
   logic                  free_rd, fits, split, found, merge, alloc_hit;
   logic                  mem_we, mem_re;
   logic [ADDR_W:0]       mem_byte;
   logic [WORD_W-1:0]     mem_wdata;
   logic [WA_W-1:0]       ram_addr;
   logic [WORD_W-1:0]     ram_wdata;
   logic                  ram_we;

   ffha_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HEAP_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (mem_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rdata)
   );

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign p_ext     = {1'b0, p_ff};
   assign p4        = p_ext + HDR_L;
   assign nx_ext    = {1'b0, nx_ff};
   assign sz_rd     = rdata & SIZE_MASK;
   assign free_rd   = rdata[0];
   assign fits      = ({{(WORD_W - REQ_W - 1){1'b0}}, want_ff} <= sz_rd);
   assign diff      = sz_rd - {{(WORD_W - REQ_W - 1){1'b0}}, want_ff};
   assign split     = (diff > WORD_W'(HEADER_BYTES));
   assign alloc_hit = fits && free_rd;
   assign found     = (p4 == {{(ADDR_W + 1 - OFF_W){1'b0}}, off_ff});
   assign merge     = have_prev_ff && prev_free_ff;

   // Shared walker adder: base or a size, plus a size, plus header.
   always_comb begin
      add_a = p_ext;
      add_b = {2'b00, sz_rd};
      unique case (state_ff)
         S_SIZE: begin
            if (op_ff == OP_ALLOC && alloc_hit) begin
               add_b = {{(ADDR_W - REQ_W){1'b0}}, want_ff};
            end else if (op_ff == OP_FREE && found && merge) begin
               add_a = {2'b00, prev_sz_ff};
            end
         end
         S_NXRD: add_b = {2'b00, size_ff};
         S_NXSZ: add_a = {2'b00, size_ff};
         default: ;
      endcase
   end
   assign sum = add_a + add_b + HDR_L;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      want_in       = want_ff;
      off_in        = off_ff;
      p_in          = p_ff;
      prev_p_in     = prev_p_ff;
      prev_sz_in    = prev_sz_ff;
      prev_free_in  = prev_free_ff;
      have_prev_in  = have_prev_ff;
      size_in       = size_ff;
      nx_in         = nx_ff;
      rem_in        = rem_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_byte      = p_ext;
      mem_wdata     = MAGIC_WORD;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               op_in        = op_type'(req_bus.operation);
               want_in      = {1'b0, req_bus.request_bytes}
                              + {{REQ_W{1'b0}}, req_bus.request_bytes[0]};
               off_in       = req_bus.block_offset;
               p_in         = '0;
               have_prev_in = 1'b0;
               res_off_in   = '0;
               priority if (op_type'(req_bus.operation) == OP_ALLOC
                            && req_bus.request_bytes == '0) begin
                  res_status_in = ST_ZERO_SIZE;
                  state_in      = S_RESP;
               end else if (op_type'(req_bus.operation) == OP_NONE) begin
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (op_ff == OP_CHECK) begin
               priority if (p_ext >= HEAP_END) begin
                  res_status_in = (p_ext == HEAP_END) ? ST_OK : ST_CORRUPT;
                  state_in      = S_RESP;
               end else if (p4 > HEAP_END) begin
                  res_status_in = ST_CORRUPT;
                  state_in      = S_RESP;
               end else begin
                  mem_re   = 1'b1;
                  state_in = S_MAGIC;
               end
            end else if (p4 > HEAP_END) begin
               res_status_in = (op_ff == OP_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               mem_re   = 1'b1;
               mem_byte = p_ext + TWO_L;
               state_in = S_SIZE;
            end
         end
         S_MAGIC: begin
            if (rdata != MAGIC_WORD) begin
               res_status_in = ST_CORRUPT;
               state_in      = S_RESP;
            end else begin
               mem_re   = 1'b1;
               mem_byte = p_ext + TWO_L;
               state_in = S_SIZE;
            end
         end
         S_SIZE: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (alloc_hit) begin
                     res_off_in = p4[OFF_W-1:0];
                     nx_in      = sum[ADDR_W-1:0];
                     rem_in     = diff - WORD_W'(HEADER_BYTES);
                     if (split) begin
                        size_in  = {{(WORD_W - REQ_W - 1){1'b0}}, want_ff};
                        state_in = S_SPL_MAG;
                     end else begin
                        size_in  = sz_rd;
                        state_in = S_HDR_SIZE;
                     end
                  end else begin
                     p_in     = sum[ADDR_W-1:0];
                     state_in = S_WALK;
                  end
               end
               OP_FREE: begin
                  if (found) begin
                     if (merge) begin
                        size_in = sum[WORD_W-1:0];
                        p_in    = prev_p_ff;
                     end else begin
                        size_in = sz_rd;
                     end
                     state_in = S_NXRD;
                  end else begin
                     prev_p_in    = p_ff;
                     prev_sz_in   = sz_rd;
                     prev_free_in = free_rd;
                     have_prev_in = 1'b1;
                     p_in         = sum[ADDR_W-1:0];
                     state_in     = S_WALK;
                  end
               end
               default: begin
                  p_in     = sum[ADDR_W-1:0];
                  state_in = S_WALK;
               end
            endcase
         end
         S_NXRD: begin
            if (sum + HDR_L <= HEAP_END) begin
               mem_re   = 1'b1;
               mem_byte = sum + TWO_L;
               state_in = S_NXSZ;
            end else begin
               state_in = S_HDR_SIZE;
            end
         end
         S_NXSZ: begin
            if (free_rd) begin
               size_in = sum[WORD_W-1:0];
            end
            state_in = S_HDR_SIZE;
         end
         S_SPL_MAG: begin
            mem_we   = 1'b1;
            mem_byte = nx_ext;
            state_in = S_SPL_SIZE;
         end
         S_SPL_SIZE: begin
            mem_we    = 1'b1;
            mem_byte  = nx_ext + TWO_L;
            mem_wdata = (rem_ff & SIZE_MASK) | FREE_BIT;
            state_in  = S_HDR_SIZE;
         end
         S_HDR_SIZE: begin
            mem_we    = 1'b1;
            mem_byte  = p_ext + TWO_L;
            mem_wdata = (op_ff == OP_FREE) ? ((size_ff & SIZE_MASK) | FREE_BIT)
                                           : (size_ff & SIZE_MASK);
            state_in  = S_HDR_MAG;
         end
         S_HDR_MAG: begin
            mem_we        = 1'b1;
            res_status_in = ST_OK;
            state_in      = S_RESP;
         end
         S_RESP: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Clearing pass seeds the single free block; walker writes drop when
   // the address leaves the heap.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_addr  = clr_ff;
         ram_wdata = (clr_ff == '0) ? MAGIC_WORD
                   : (clr_ff == WA_W'(1)) ? INIT_SIZE : '0;
      end else begin
         ram_we    = mem_we && (mem_byte < HEAP_END);
         ram_addr  = mem_byte[WA_W:1];
         ram_wdata = mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      want_ff       <= want_in;
      off_ff        <= off_in;
      p_ff          <= p_in;
      prev_p_ff     <= prev_p_in;
      prev_sz_ff    <= prev_sz_in;
      prev_free_ff  <= prev_free_in;
      have_prev_ff  <= have_prev_in;
      size_ff       <= size_in;
      nx_ff         <= nx_in;
      rem_ff        <= rem_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.data_offset = rsp_off_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_SPL_MAG
                  || state_ff == S_SPL_SIZE || state_ff == S_HDR_SIZE
                  || state_ff == S_HDR_MAG))
      else $error("heap written outside a write step");

   a_offset_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_off_ff != '0 |-> rsp_status_ff == ST_OK)
      else $error("data offset on a failed result");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff != S_IDLE)
      else $error("accepted beat did not start work");

   a_split_needs_alloc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPL_MAG |-> op_ff == OP_ALLOC)
      else $error("split step outside allocate");
endmodule

// ===== dv/first_fit_heap_allocator_test.sv =====
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;
   import ffha_pkg::*;

   localparam int unsigned HEAP_B   = 4096;
   localparam int unsigned HWORDS   = HEAP_B / 2;
   localparam int          WD_LIMIT = 40000;

   typedef struct packed {
      status_type       status;
      logic [OFF_W-1:0] data_offset;
   } heap_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   ffha_req_if req_bus ();
   ffha_rsp_if rsp_bus ();

   first_fit_heap_allocator #(.HEAP_BYTES(HEAP_B)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   logic [WORD_W-1:0] heap_mirror [HWORDS];
   heap_result_t      pending_results[$];
   int                error_count = 0;
   int                idle_cycles = 0;
   // data offsets currently handed out, used to aim frees at real blocks
   int unsigned       live_offsets[$];

   // ---------------- heap mirror ----------------
   function automatic int unsigned rd_word(int unsigned a);
      int unsigned i;
      i = a >> 1;
      return (i < HWORDS) ? int'(heap_mirror[i]) : 0;
   endfunction

   function automatic void wr_word(int unsigned a, int unsigned v);
      int unsigned i;
      i = a >> 1;
      if (i < HWORDS) heap_mirror[i] = v[15:0];
   endfunction

   function automatic int unsigned size_of(int unsigned p);
      return rd_word(p + 2) & SIZE_MASK;
   endfunction

   function automatic int unsigned is_free(int unsigned p);
      return rd_word(p + 2) & FREE_BIT;
   endfunction

   function automatic void set_size(int unsigned p, int unsigned s);
      wr_word(p + 2, (s & SIZE_MASK) | is_free(p));
   endfunction

   function automatic void heap_init();
      foreach (heap_mirror[i]) heap_mirror[i] = '0;
      wr_word(0, MAGIC_WORD);
      wr_word(2, ((HEAP_B - HEADER_BYTES) & SIZE_MASK) | FREE_BIT);
   endfunction

   function automatic heap_result_t allocate_block(int unsigned req);
      heap_result_t r;
      int unsigned want, p, sz, nx;
      r.status = ST_NO_SPACE;
      r.data_offset = '0;
      want = req + (req & 1);
      p = 0;
      if (want == 0) begin
         r.status = ST_ZERO_SIZE;
         return r;
      end
      while (p + HEADER_BYTES <= HEAP_B) begin
         sz = size_of(p);
         if (sz >= want && is_free(p) != 0) begin
            if (sz - want > HEADER_BYTES) begin
               nx = p + HEADER_BYTES + want;
               wr_word(nx, MAGIC_WORD);
               wr_word(nx + 2, ((sz - want - HEADER_BYTES) & SIZE_MASK) | FREE_BIT);
               wr_word(p + 2, want & SIZE_MASK);
            end
            wr_word(p + 2, rd_word(p + 2) & SIZE_MASK);
            wr_word(p, MAGIC_WORD);
            r.status = ST_OK;
            r.data_offset = 12'(p + HEADER_BYTES);
            return r;
         end
         p += sz + HEADER_BYTES;
      end
      return r;
   endfunction

   function automatic status_type release_block(int unsigned off);
      int unsigned p, prev, cur, nx;
      bit have_prev;
      p = 0;
      prev = 0;
      have_prev = 0;
      while (p + HEADER_BYTES <= HEAP_B) begin
         if (p + HEADER_BYTES == off) begin
            cur = p;
            if (have_prev && is_free(prev) != 0) begin
               set_size(prev, size_of(prev) + size_of(p) + HEADER_BYTES);
               cur = prev;
            end
            nx = cur + size_of(cur) + HEADER_BYTES;
            if (nx + HEADER_BYTES <= HEAP_B && is_free(nx) != 0)
               set_size(cur, size_of(cur) + size_of(nx) + HEADER_BYTES);
            wr_word(cur, MAGIC_WORD);
            wr_word(cur + 2, rd_word(cur + 2) | FREE_BIT);
            return ST_OK;
         end
         prev = p;
         have_prev = 1;
         p += size_of(p) + HEADER_BYTES;
      end
      return ST_NOT_FOUND;
   endfunction

   function automatic status_type walk_chain();
      int unsigned p;
      p = 0;
      while (p < HEAP_B) begin
         if (p + HEADER_BYTES > HEAP_B) return ST_CORRUPT;
         if (rd_word(p) != MAGIC_WORD) return ST_CORRUPT;
         p += size_of(p) + HEADER_BYTES;
      end
      return (p == HEAP_B) ? ST_OK : ST_CORRUPT;
   endfunction

   function automatic heap_result_t predict_result(op_type op, int unsigned req,
                                                   int unsigned off);
      heap_result_t r;
      r.status = ST_OK;
      r.data_offset = '0;
      case (op)
         OP_ALLOC: begin
            r = allocate_block(req);
            if (r.status == ST_OK) live_offsets.push_back(r.data_offset);
         end
         OP_FREE: begin
            r.status = release_block(off);
            foreach (live_offsets[i])
               if (live_offsets[i] == off) begin
                  live_offsets.delete(i);
                  break;
               end
         end
         OP_CHECK: r.status = walk_chain();
         default: ;
      endcase
      return r;
   endfunction

   // ---------------- driving ----------------
   // valid stays high into the next call so a zero gap is one assignment
   task automatic send_request(op_type op, int unsigned req, int unsigned off);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.request_bytes <= req[REQ_W-1:0];
      req_bus.block_offset  <= off[OFF_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_result(op, req, off));
   endtask

   // ---------------- result checking ----------------
   initial begin
      int stall;
      heap_result_t exp_r;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat status=%0d data_offset=%0d",
                     $time, rsp_bus.status, rsp_bus.data_offset);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_bus.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_r.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.data_offset !== exp_r.data_offset) begin
               $display("%0t: data_offset expected %0d actual %0d",
                        $time, exp_r.data_offset, rsp_bus.data_offset);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("FAIL first_fit_heap_allocator");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_state();
      send_request(OP_CHECK, 0, 0);
      send_request(OP_NONE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      send_request(OP_FREE, 0, 0);
      send_request(OP_FREE, 0, 4);
   endtask

   task automatic test_alloc_edges();
      send_request(OP_ALLOC, 0, 4095);
      send_request(OP_ALLOC, 8191, 0);
      send_request(OP_ALLOC, 4096, 0);
      send_request(OP_ALLOC, 4092, 0);
      send_request(OP_ALLOC, 2, 0);
      send_request(OP_FREE, 0, 4);
      // small remainder: 4090 leaves 2 bytes, handed out whole
      send_request(OP_ALLOC, 4089, 0);
      send_request(OP_CHECK, 0, 0);
      send_request(OP_FREE, 0, 4);
      send_request(OP_ALLOC, 4087, 0);
      send_request(OP_FREE, 0, 4);
   endtask

   task automatic test_free_merge();
      send_request(OP_ALLOC, 7, 0);
      send_request(OP_ALLOC, 10, 0);
      send_request(OP_ALLOC, 1, 0);
      send_request(OP_FREE, 0, 4);
      send_request(OP_FREE, 0, 24);
      send_request(OP_FREE, 0, 24);
      send_request(OP_FREE, 0, 16);
      send_request(OP_FREE, 0, 16);
      send_request(OP_FREE, 0, 4);
      send_request(OP_FREE, 0, 4095);
      send_request(OP_CHECK, 0, 0);
   endtask

   task automatic test_random_mix(int n);
      int unsigned kind, req, off;
      for (int k = 0; k < n; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 200);
            send_request(OP_ALLOC, req, $urandom_range(0, 4095));
         end else if (kind < 85) begin
            if (live_offsets.size() > 0 && $urandom_range(0, 7) != 0)
               off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
            else
               off = $urandom_range(0, 4095);
            send_request(OP_FREE, $urandom_range(0, 8191), off);
         end else if (kind < 97) begin
            send_request(OP_CHECK, $urandom_range(0, 8191), $urandom_range(0, 4095));
         end else begin
            send_request(OP_NONE, $urandom_range(0, 8191), $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_NONE;
      req_bus.request_bytes <= '0;
      req_bus.block_offset  <= '0;
      heap_init();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_alloc_edges();
      test_free_merge();
      test_random_mix(1250);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("PASS first_fit_heap_allocator");
      else
         $display("FAIL first_fit_heap_allocator");
      $finish;
   end

endmodule
